/* sv/sli_pkg.sv */
// shared types and constants for the positional list
package sli_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned LEN_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  // request kinds
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  // per-cycle shift operation broadcast along the chain
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_INS   = 2'd1,
    OP_DEL   = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   at;
    logic [DATA_W-1:0]  value;
  } chain_ctrl_t;

endpackage

/* sv/sli_cell.sv */
// one list entry: holds, takes from its lower or upper neighbour, or loads a new value
module sli_cell (
  input  logic                       clk_i,
  input  logic [sli_pkg::IDX_W-1:0]  idx_i,
  input  sli_pkg::chain_ctrl_t       ctrl_i,
  input  logic [sli_pkg::DATA_W-1:0] left_i,
  input  logic [sli_pkg::DATA_W-1:0] right_i,
  output logic [sli_pkg::DATA_W-1:0] data_o
);
  import sli_pkg::*;

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  // next entry value from the broadcast operation
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      OP_INS: begin
        if (idx_i == ctrl_i.at) begin
          data_d = ctrl_i.value;
        end else if (idx_i > ctrl_i.at) begin
          data_d = left_i;
        end
      end
      OP_DEL: begin
        if (idx_i >= ctrl_i.at) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* sv/sli_chain.sv */
// row of entry cells with neighbour links and the positional read select
module sli_chain (
  input  logic                       clk_i,
  input  sli_pkg::chain_ctrl_t       ctrl_i,
  input  logic [sli_pkg::IDX_W-1:0]  rd_idx_i,
  output logic [sli_pkg::DATA_W-1:0] rd_data_o
);
  import sli_pkg::*;

  logic [DATA_W-1:0] cell_data [CAPACITY];

  // cells linked to both neighbours; the first sees zero on its lower side, the last sees itself above
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    sli_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctrl_i  (ctrl_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  // positional read select
  assign rd_data_o = cell_data[rd_idx_i];

endmodule

/* sv/sequential_list_insert_delete.sv */
// positional list: insert, run delete and read over a chain of entry cells
// all requests, run deletes included: result registered in the cycle after acceptance
// a run delete of n entries shifts the chain down once per cycle, stalling the
// input until the run is done; throughput is one request per cycle otherwise
// a result not yet taken holds off the next request
// reset clears the length count and the output valid; entry contents and length_o are not cleared
module sequential_list_insert_delete (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        kind_i,
  input  logic [10:0]                       position_i,
  input  logic [10:0]                       count_i,
  input  logic signed [sli_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [sli_pkg::DATA_W-1:0] read_value_o,
  output logic [sli_pkg::LEN_W-1:0]         length_o
);
  import sli_pkg::*;

  localparam int unsigned CMP_W = LEN_W + 1;

  logic [LEN_W-1:0]  used_q, used_d;
  logic [LEN_W-1:0]  del_left_q, del_left_d;
  logic [IDX_W-1:0]  del_at_q, del_at_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] rd_q, rd_d;
  logic [LEN_W-1:0]  len_q;

  logic              accept;
  logic              busy;
  logic [CMP_W-1:0]  pos_w, cnt_w, used_w, pos_m1;
  logic              ins_bad, full, del_bad, rd_bad;
  logic [DATA_W-1:0] rd_data;
  chain_ctrl_t       ctrl;
  kind_e             kind;

  assign kind   = kind_e'(kind_i);
  assign busy   = (del_left_q != '0);
  assign in_ready_o = !busy && (!out_valid_q || out_ready_i);
  assign accept = in_valid_i && in_ready_o;

  // range checks on the request
  assign pos_w   = CMP_W'(position_i);
  assign cnt_w   = CMP_W'(count_i);
  assign used_w  = CMP_W'(used_q);
  assign pos_m1  = pos_w - CMP_W'(1);
  assign ins_bad = (position_i == '0) || (pos_w > used_w + CMP_W'(1));
  assign full    = (used_q >= LEN_W'(CAPACITY));
  assign del_bad = (position_i == '0) || (pos_m1 + cnt_w > used_w);
  assign rd_bad  = (position_i == '0) || (pos_w > used_w);

  // operation broadcast to the chain
  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.at    = pos_m1[IDX_W-1:0];
    ctrl.value = value_i;
    if (busy) begin
      ctrl.op = OP_DEL;
      ctrl.at = del_at_q;
    end else if (accept && kind == KIND_INSERT && !ins_bad && !full) begin
      ctrl.op = OP_INS;
    end
  end

  sli_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rd_idx_i  (pos_m1[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  // request decode, length update and result
  always_comb begin
    used_d      = used_q;
    del_left_d  = del_left_q;
    del_at_d    = del_at_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    rd_d        = rd_q;

    if (busy) begin
      del_left_d = del_left_q - LEN_W'(1);
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      rd_d        = '0;
      unique case (kind)
        KIND_INSERT: begin
          if (ins_bad) begin
            status_d = ST_BAD_POS;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            used_d = used_q + LEN_W'(1);
          end
        end
        KIND_DELETE: begin
          if (del_bad) begin
            status_d = ST_BAD_POS;
          end else begin
            used_d     = used_q - count_i[LEN_W-1:0];
            del_left_d = count_i[LEN_W-1:0];
            del_at_d   = pos_m1[IDX_W-1:0];
          end
        end
        KIND_READ: begin
          if (rd_bad) begin
            status_d = ST_BAD_POS;
          end else begin
            rd_d = rd_data;
          end
        end
        default: status_d = ST_BAD_POS;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      del_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      del_left_q  <= del_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload and delete start point
  always_ff @(posedge clk_i) begin
    del_at_q <= del_at_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    if (accept) begin
      len_q <= used_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = rd_q;
  assign length_o     = len_q;

endmodule

/* bench/testbench.sv */
// self-checking bench for the positional list: requests, result checks and stall patterns
`timescale 1ns / 100ps

module testbench;
  import sli_pkg::*;

  typedef struct {
    status_e                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic [LEN_W-1:0]          length;
  } list_result_t;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_ONE_IN_FOUR,
    RX_MOSTLY
  } rx_mode_e;

  localparam int MAX_FIELD = 2047;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                kind_i = KIND_READ;
  logic [10:0]               position_i = '0;
  logic [10:0]               count_i = '0;
  logic signed [DATA_W-1:0]  value_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [1:0]                status_o;
  logic signed [DATA_W-1:0]  read_value_o;
  logic [LEN_W-1:0]          length_o;

  // shadow copy of the list
  logic signed [DATA_W-1:0]  shadow_entries [CAPACITY];
  int                        shadow_length = 0;

  list_result_t              pending_results [$];
  int                        error_count = 0;
  int                        burst_left = 0;

  rx_mode_e                  rx_mode = RX_ALWAYS;
  int                        rx_left = 0;
  int                        rx_tick = 0;

  sequential_list_insert_delete DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .count_i      (count_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .length_o     (length_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one request to the shadow list and return the result it should give
  function automatic list_result_t apply_list_request(input kind_e kind, input logic [10:0] pos,
                                                      input logic [10:0] cnt,
                                                      input logic signed [DATA_W-1:0] val);
    list_result_t r;
    int p;
    int c;
    int i;
    r.status     = ST_OK;
    r.read_value = '0;
    p = pos;
    c = cnt;
    case (kind)
      KIND_INSERT: begin
        if (p < 1 || p > shadow_length + 1) begin
          r.status = ST_BAD_POS;
        end else if (shadow_length >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_length; i > p - 1; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p-1] = val;
          shadow_length++;
        end
      end
      KIND_DELETE: begin
        if (p < 1 || (p - 1) + c > shadow_length) begin
          r.status = ST_BAD_POS;
        end else if (c > 0) begin
          for (i = p - 1; i < shadow_length - c; i++) shadow_entries[i] = shadow_entries[i+c];
          shadow_length -= c;
        end
      end
      KIND_READ: begin
        if (p < 1 || p > shadow_length) r.status = ST_BAD_POS;
        else r.read_value = shadow_entries[p-1];
      end
      default: r.status = ST_BAD_POS;
    endcase
    r.length = shadow_length[LEN_W-1:0];
    return r;
  endfunction

  // drive one request, idling between bursts, and record its result on acceptance
  task automatic send_request(input kind_e kind, input int pos, input int cnt,
                              input logic [DATA_W-1:0] val);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    position_i <= pos[10:0];
    count_i    <= cnt[10:0];
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(apply_list_request(kind, pos[10:0], cnt[10:0], val));
  endtask

  // boundaries of every field and the out of range cases on a short list
  task automatic test_edge_cases();
    send_request(KIND_READ,   1,    0, 32'h0);
    send_request(KIND_INSERT, 0,    0, 32'h1234_5678);
    send_request(KIND_INSERT, 2,    0, 32'h1234_5678);
    send_request(KIND_INSERT, 1,    0, 32'h7FFF_FFFF);
    send_request(KIND_INSERT, 1,    0, 32'h8000_0000);
    send_request(KIND_INSERT, 3,    0, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 2,    0, 32'h0);
    send_request(KIND_INSERT, MAX_FIELD, MAX_FIELD, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 1025, 0, 32'h5555_AAAA);
    for (int i = 1; i <= 4; i++) send_request(KIND_READ, i, MAX_FIELD, 32'hAAAA_5555);
    send_request(KIND_READ,   5,    0, 32'h0);
    send_request(KIND_READ,   0,    0, 32'h0);
    send_request(KIND_READ,   MAX_FIELD, 0, 32'h0);
    // zero-length deletes up to one past the end, then just beyond
    send_request(KIND_DELETE, 2,    0, 32'h0);
    send_request(KIND_DELETE, 5,    0, 32'h0);
    send_request(KIND_DELETE, 6,    0, 32'h0);
    send_request(KIND_DELETE, 0,    1, 32'h0);
    send_request(KIND_DELETE, 3,    3, 32'h0);
    send_request(KIND_DELETE, 1,    MAX_FIELD, 32'h0);
    send_request(KIND_DELETE, 2,    2, 32'hFFFF_FFFF);
    send_request(KIND_UNUSED, 1,    1, 32'h0000_0001);
    send_request(KIND_UNUSED, MAX_FIELD, MAX_FIELD, 32'hFFFF_FFFF);
    send_request(KIND_DELETE, 1,    2, 32'h0);
    send_request(KIND_READ,   1,    0, 32'h0);
  endtask

  // grow the list to capacity with inserts at random places and some reads
  task automatic test_fill_to_capacity();
    while (shadow_length < CAPACITY) begin
      if (shadow_length > 0 && $urandom_range(0, 99) < 4)
        send_request(KIND_READ, $urandom_range(1, shadow_length), $urandom_range(0, MAX_FIELD),
                     $urandom);
      else
        send_request(KIND_INSERT, $urandom_range(1, shadow_length + 1),
                     $urandom_range(0, MAX_FIELD), $urandom);
    end
  endtask

  // behaviour at capacity, then shrink to a short list with one long run delete
  task automatic test_full_list();
    send_request(KIND_INSERT, 1,    0, $urandom);
    send_request(KIND_INSERT, 1025, 0, $urandom);
    send_request(KIND_INSERT, 513,  0, $urandom);
    send_request(KIND_INSERT, 1026, 0, $urandom);
    send_request(KIND_INSERT, 0,    0, $urandom);
    send_request(KIND_READ,   1024, 0, 32'h0);
    send_request(KIND_READ,   1025, 0, 32'h0);
    send_request(KIND_DELETE, 1025, 0, 32'h0);
    send_request(KIND_DELETE, 1024, 2, 32'h0);
    send_request(KIND_DELETE, 1024, 1, 32'h0);
    send_request(KIND_INSERT, 1024, 0, $urandom);
    send_request(KIND_READ,   1024, 0, 32'h0);
    send_request(KIND_DELETE, 1,    1, 32'h0);
    send_request(KIND_READ,   1,    0, 32'h0);
    send_request(KIND_DELETE, 11, shadow_length - 10, 32'h0);
  endtask

  // mixed traffic on a short list, mostly well formed, some noise
  task automatic test_random_mix(input int n_requests);
    int sel;
    int p;
    int c;
    int room;
    repeat (n_requests) begin
      sel = $urandom_range(0, 99);
      p = $urandom_range(1, shadow_length + 1);
      if (sel < 40) begin
        if ($urandom_range(0, 9) == 0) p = shadow_length + 2;
        send_request(KIND_INSERT, p, $urandom_range(0, MAX_FIELD), $urandom);
      end else if (sel < 65) begin
        send_request(KIND_READ, p, $urandom_range(0, MAX_FIELD), $urandom);
      end else if (sel < 90) begin
        room = shadow_length - p + 1;
        if (sel < 80) c = $urandom_range(0, (room < 4) ? room : 4);
        else if (sel < 87) c = $urandom_range(0, room);
        else c = room + $urandom_range(1, 3);
        send_request(KIND_DELETE, p, c, $urandom);
      end else begin
        send_request(kind_e'($urandom_range(0, 3)), $urandom_range(0, MAX_FIELD),
                     $urandom_range(0, MAX_FIELD), $urandom);
      end
    end
    // empty the list and poke it once more
    send_request(KIND_DELETE, 1, shadow_length, 32'h0);
    send_request(KIND_READ,   1, 0, 32'h0);
    send_request(KIND_INSERT, 1, 0, $urandom);
    send_request(KIND_READ,   1, 0, 32'h0);
  endtask

  // receiver readiness, switching between patterns of its own
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS:      out_ready_i <= 1'b1;
      RX_COIN:        out_ready_i <= ($urandom_range(0, 1) == 1);
      RX_ONE_IN_FOUR: out_ready_i <= (rx_tick % 4 == 0);
      default:        out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // compare each accepted result with the oldest outstanding one
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (read_value_o !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, read_value_o);
          error_count++;
        end
        if (length_o !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, length_o);
          error_count++;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_edge_cases();
    test_fill_to_capacity();
    test_full_list();
    test_random_mix(100);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // long enough for a full-length run delete to show any stray result
    repeat (1100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
